// File: src/jobf_pkg.sv
`default_nettype none

package jobf_pkg;

  // Default sizes.
  localparam int unsigned MAX_DEPTH_DEF  = 64;
  localparam int unsigned MAX_BUFFER_DEF = 65536;

  // Field widths fixed by the interface.
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 16;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_START = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WAITING  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_DEEP = 3'd4;

  // Characters the scanner reacts to.
  localparam logic [DATA_W-1:0] CH_NUL    = 8'h00;
  localparam logic [DATA_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [DATA_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [DATA_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [DATA_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [DATA_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [DATA_W-1:0] CH_RBRACE = 8'h7D;

  // Scan phase, one-hot.
  typedef enum logic [2:0] {
    PH_SEEK  = 3'b001,
    PH_SCAN  = 3'b010,
    PH_DRAIN = 3'b100
  } phase_t;

endpackage

`default_nettype wire

// File: src/json_object_boundary_finder_core.sv
// JSON object boundary finder.
// The input channel carries one text byte per beat (in_data_byte) with
// in_end_of_buffer marking the last byte of a buffer. The block skips bytes
// until the first '{', then tracks nested '{' and '[' on a one-bit stack
// held in a shift register, ignoring brackets inside quoted strings and
// skipping the byte after a backslash. At most one result beat per buffer is
// sent on the output channel: status, start_pos and stop_pos.
// An input beat lands in an input register; when the result slot is free,
// one pass of logic updates the scan state and loads the result register,
// so a result passes through both registers. One byte is taken every
// cycle; the only limit is the result register, which holds its beat while
// out_stall is high and then back-pressures the input through in_stall.
// A byte at offset MAX_BUFFER-1 ends its buffer even without
// in_end_of_buffer. Synchronous active-low reset empties both registers
// and starts a fresh buffer: phase seeking, depth zero, offset zero.
`default_nettype none

module json_object_boundary_finder_core #(
  parameter int unsigned MAX_DEPTH  = jobf_pkg::MAX_DEPTH_DEF,
  parameter int unsigned MAX_BUFFER = jobf_pkg::MAX_BUFFER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [jobf_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                            in_end_of_buffer,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [jobf_pkg::STATUS_W-1:0]   out_status,
  output logic [jobf_pkg::POS_W-1:0]      out_start_pos,
  output logic [jobf_pkg::POS_W-1:0]      out_stop_pos
);
  import jobf_pkg::*;

  // Depth counter must hold MAX_DEPTH itself; the offset counter spans a buffer.
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned PW = $clog2(MAX_BUFFER);

  // Input register.
  logic              in_valid_r;
  logic [DATA_W-1:0] in_data_r;
  logic              in_eob_r;

  // Scan state. The stack top sits in bit 0; a push shifts toward the
  // high end, so only bit 0 is ever read.
  logic [MAX_DEPTH-1:0] stack_r, stack_nxt;
  logic [DW-1:0]        depth_r, depth_nxt;
  logic                 in_str_r, in_str_nxt;
  logic                 esc_r, esc_nxt;
  phase_t               phase_r, phase_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [PW-1:0]        start_r, start_nxt;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [POS_W-1:0]    start_pos_r;
  logic [POS_W-1:0]    stop_pos_r;

  // Result of the current pass.
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [PW-1:0]       res_start;
  logic [PW-1:0]       res_stop;

  logic                advance;
  logic                last;

  // Zero-extended offsets, cut down to the port width.
  logic [PW+POS_W-1:0] res_start_ext;
  logic [PW+POS_W-1:0] res_stop_ext;

  // The held byte is processed whenever the result slot is free or
  // being emptied in this cycle.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign last     = in_eob_r || (pos_r == PW'(MAX_BUFFER - 1));

  always_comb begin
    stack_nxt  = stack_r;
    depth_nxt  = depth_r;
    in_str_nxt = in_str_r;
    esc_nxt    = esc_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    res_valid  = 1'b0;
    res_status = ST_COMPLETE;
    res_start  = start_r;
    res_stop   = pos_r;

    case (phase_r)
      PH_SEEK: begin
        if (in_data_r == CH_LBRACE) begin
          start_nxt  = pos_r;
          stack_nxt  = {stack_r[MAX_DEPTH-2:0], 1'b1};
          depth_nxt  = DW'(1);
          in_str_nxt = 1'b0;
          esc_nxt    = 1'b0;
          phase_nxt  = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (in_data_r == CH_NUL) begin
          res_valid  = 1'b1;
          res_status = ST_WAITING;
        end else if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (in_data_r == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (in_data_r == CH_QUOTE) begin
          in_str_nxt = !in_str_r;
        end else if (!in_str_r) begin
          if (in_data_r == CH_LBRACE || in_data_r == CH_LBRACK) begin
            if (depth_r >= DW'(MAX_DEPTH)) begin
              res_valid  = 1'b1;
              res_status = ST_TOO_DEEP;
            end else begin
              stack_nxt = {stack_r[MAX_DEPTH-2:0], (in_data_r == CH_LBRACE)};
              depth_nxt = depth_r + DW'(1);
            end
          end else if (in_data_r == CH_RBRACE || in_data_r == CH_RBRACK) begin
            if (depth_r == '0 || stack_r[0] != (in_data_r == CH_RBRACE)) begin
              res_valid  = 1'b1;
              res_status = ST_ILLEGAL;
            end else begin
              stack_nxt = {1'b0, stack_r[MAX_DEPTH-1:1]};
              depth_nxt = depth_r - DW'(1);
              if (depth_r == DW'(1)) begin
                res_valid  = 1'b1;
                res_status = ST_COMPLETE;
              end
            end
          end
        end
      end
      default: begin
        // Draining: bytes are dropped until the buffer ends.
      end
    endcase

    if (res_valid) begin
      phase_nxt = PH_DRAIN;
    end else if (last) begin
      // The buffer ends without a result so far; the phase reached by this
      // byte (an opening brace on the last byte counts) decides the report.
      if (phase_nxt == PH_SEEK) begin
        res_valid  = 1'b1;
        res_status = ST_NO_START;
        res_start  = '0;
      end else if (phase_nxt == PH_SCAN) begin
        res_valid  = 1'b1;
        res_status = ST_WAITING;
        res_start  = start_nxt;
      end
    end

    if (last) begin
      depth_nxt  = '0;
      in_str_nxt = 1'b0;
      esc_nxt    = 1'b0;
      phase_nxt  = PH_SEEK;
      pos_nxt    = '0;
      start_nxt  = '0;
    end else begin
      pos_nxt = pos_r + PW'(1);
    end
  end

  assign res_start_ext = {{POS_W{1'b0}}, res_start};
  assign res_stop_ext  = {{POS_W{1'b0}}, res_stop};

  // Input register: reloads whenever it is not holding a stalled byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data_byte;
      in_eob_r  <= in_end_of_buffer;
    end
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      in_str_r <= 1'b0;
      esc_r    <= 1'b0;
      phase_r  <= PH_SEEK;
      pos_r    <= '0;
      start_r  <= '0;
    end else if (advance) begin
      depth_r  <= depth_nxt;
      in_str_r <= in_str_nxt;
      esc_r    <= esc_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
    end
  end

  // Stack contents need no reset: an entry is always pushed before it is read.
  always_ff @(posedge clk) begin
    if (advance) begin
      stack_r <= stack_nxt;
    end
  end

  // Result register: holds its beat while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      status_r    <= res_status;
      start_pos_r <= res_start_ext[POS_W-1:0];
      stop_pos_r  <= res_stop_ext[POS_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_start_pos = start_pos_r;
  assign out_stop_pos  = stop_pos_r;

`ifndef SYNTHESIS
  // The depth counter never passes the stack size.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("bracket depth beyond stack size");

  // While seeking an opening brace the stack is empty.
  a_seek_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SEEK) |-> (depth_r == '0))
    else $error("stack not empty while seeking");

  // While scanning at least the outer brace is open; closing it ends the scan.
  a_scan_open: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SCAN) |-> (depth_r != '0))
    else $error("scanning with an empty stack");

  // A processed byte that yields a result leaves the result register full.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |=> out_valid_r)
    else $error("result lost");
`endif

endmodule

`default_nettype wire
